// ----- hw/rtl/reference_element_segment_clip_macros.svh -----
// Assertion macros used by the segment clipping RTL.
`ifndef REFERENCE_ELEMENT_SEGMENT_CLIP_MACROS_SVH
`define REFERENCE_ELEMENT_SEGMENT_CLIP_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define RESC_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("resc assertion failed");
// Condition that must never be true outside reset.
`define RESC_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("resc forbidden condition seen");
`else
`define RESC_ASSERT(label, clk, rstn, prop)
`define RESC_NEVER(label, clk, rstn, cond)
`endif
`endif

// ----- hw/rtl/resc_pkg.sv -----
// Shape codes and status codes of the reference element segment clipper.
package resc_pkg;

  // Shape codes carried in the input tuser.
  localparam logic [2:0] GEOM_POINT = 3'd0;
  localparam logic [2:0] GEOM_SEG   = 3'd1;
  localparam logic [2:0] GEOM_TRI   = 3'd2;
  localparam logic [2:0] GEOM_SQUARE = 3'd3;
  localparam logic [2:0] GEOM_TET   = 3'd4;
  localparam logic [2:0] GEOM_CUBE  = 3'd5;

  // Result status carried in the output tuser.
  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_CLIPPED = 2'd1,
    ST_BAD     = 2'd2
  } status_e;

  // Number of facet lanes (the cube has the most facets).
  localparam int NUM_LANES = 6;

endpackage

// ----- hw/rtl/reference_element_segment_clip.sv -----
// Top level of the reference element segment clipper.

// Clips the segment from begin to end against a reference shape and returns
// end, or the point where the segment first leaves the shape. The block takes
// one transfer every cycle while the output is not stalled and returns results
// in order. Each item passes through the crossing-fraction divider, which
// resolves one quotient bit per pipeline stage for all six facets at once,
// followed by two minimum stages, a multiply stage and the output register.
// Stalls on the output fill bubbles first, so the input keeps accepting
// while any stage is empty.
`include "reference_element_segment_clip_macros.svh"

module reference_element_segment_clip #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input stream.
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // tdata from bit 0: beg_x, beg_y, beg_z, end_x, end_y, end_z, zero pad.
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,
  // tuser from bit 0: geom_type.
  input  logic [2:0]                            s_axis_tuser_i,
  // Output stream.
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // tdata from bit 0: out_x, out_y, out_z, zero pad.
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata_o,
  // tuser from bit 0: status.
  output logic [1:0]                            m_axis_tuser_o
);

  localparam int CW = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NL = resc_pkg::NUM_LANES;
  localparam int MW = (CW > F + 1) ? CW : F + 2;
  localparam int FW = MW + 2;          // signed facet value
  localparam int DW = FW + 1;          // unsigned divisor and remainder
  localparam int TW = F + 1;           // crossing fraction up to 1.0
  localparam int PW = TW + CW + 2;     // signed product
  localparam int RW = PW + 1;          // interpolated coordinate before saturation
  localparam int OW = ((3 * CW + 7) / 8) * 8;
  localparam int NS = F + 6;           // number of pipeline stages
  localparam int SA = F + 2;           // first minimum stage
  localparam int SB = F + 3;           // second minimum stage
  localparam int SM = F + 4;           // multiply stage

  localparam logic signed [FW-1:0] ONE_F = FW'(1) << F;
  localparam logic [TW-1:0] ONE_T = TW'(1) << F;
  localparam logic signed [CW-1:0] ONE_C = (F <= CW - 2) ? (CW'(1) << F) :
                                           ~(CW'(1) << (CW - 1));
  localparam logic signed [CW-1:0] MAX_C = ~(CW'(1) << (CW - 1));
  localparam logic signed [CW-1:0] MIN_C = CW'(1) << (CW - 1);
  localparam logic signed [PW-1:0] HALF_P = PW'(1) << (F - 1);

  typedef struct packed {
    logic [2:0]           geom;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] ez;
    logic                 spec;
    resc_pkg::status_e    st;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
  } pay_t;

  typedef struct packed {
    logic [NL-1:0]          act;
    logic [NL-1:0][DW-1:0]  den;
    logic [NL-1:0][DW-1:0]  rem;
    logic [NL-1:0][F-1:0]   quo;
  } div_t;

  // Saturate an interpolated coordinate to the output width.
  function automatic logic signed [CW-1:0] sat_f(input logic signed [RW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > RW'(MAX_C)) begin
      r = MAX_C;
    end else if (v < RW'(MIN_C)) begin
      r = MIN_C;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  pay_t pay_q [NS-1];
  pay_t pay_d [NS-1];
  div_t div_q [F+1];
  div_t div_d [F+1];
  div_t div0_d;
  logic [2:0][TW-1:0] ta_q, ta_d;
  logic [TW-1:0] t_q, t_d;
  logic out_a_q, out_b_q, out_c_q;
  logic [2:0][PW-1:0] prod_q, prod_d;
  logic signed [CW-1:0] ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  resc_pkg::status_e st_q, st_d;

  // A stage moves when the output drains or that stage or a later one holds a bubble.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      en[k] = m_axis_tready_i | ~&(v_q | ((NS'(1) << k) - NS'(1)));
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[NS-1];
  assign m_axis_tdata_o  = OW'({oz_q, oy_q, ox_q});
  assign m_axis_tuser_o  = st_q;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? s_axis_tvalid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Input capture, facet setup and the special shapes.
  always_comb begin
    logic signed [FW-1:0] bxe, bye, bze, exe, eye, eze;
    logic signed [FW-1:0] fbr [NL];
    logic signed [FW-1:0] fer [NL];
    logic signed [FW-1:0] fbc;
    logic [NL-1:0] used;
    pay_t p;

    pay_d[0].geom = s_axis_tuser_i;
    pay_d[0].bx   = s_axis_tdata_i[CW-1:0];
    pay_d[0].by   = s_axis_tdata_i[2*CW-1:CW];
    pay_d[0].bz   = s_axis_tdata_i[3*CW-1:2*CW];
    pay_d[0].ex   = s_axis_tdata_i[4*CW-1:3*CW];
    pay_d[0].ey   = s_axis_tdata_i[5*CW-1:4*CW];
    pay_d[0].ez   = s_axis_tdata_i[6*CW-1:5*CW];
    pay_d[0].spec = 1'b0;
    pay_d[0].st   = resc_pkg::ST_INSIDE;
    pay_d[0].sx   = '0;
    pay_d[0].sy   = '0;
    pay_d[0].sz   = '0;

    for (int k = 1; k < NS - 1; k++) begin
      pay_d[k] = pay_q[k-1];
    end

    p   = pay_q[0];
    bxe = FW'(p.bx);
    bye = FW'(p.by);
    bze = FW'(p.bz);
    exe = FW'(p.ex);
    eye = FW'(p.ey);
    eze = FW'(p.ez);
    for (int i = 0; i < NL; i++) begin
      fbr[i] = '0;
      fer[i] = '0;
    end
    used = '0;

    // Special results default to end passed through.
    pay_d[1].spec = 1'b0;
    pay_d[1].st   = resc_pkg::ST_INSIDE;
    pay_d[1].sx   = p.ex;
    pay_d[1].sy   = p.ey;
    pay_d[1].sz   = p.ez;

    unique case (p.geom)
      resc_pkg::GEOM_POINT: begin
        pay_d[1].spec = 1'b1;
        if (p.ex != '0) begin
          pay_d[1].sx = '0;
          pay_d[1].st = resc_pkg::ST_CLIPPED;
        end
      end
      resc_pkg::GEOM_SEG: begin
        pay_d[1].spec = 1'b1;
        if (p.ex < 0) begin
          pay_d[1].sx = '0;
          pay_d[1].st = resc_pkg::ST_CLIPPED;
        end else if (exe > ONE_F) begin
          pay_d[1].sx = ONE_C;
          pay_d[1].st = resc_pkg::ST_CLIPPED;
        end
      end
      resc_pkg::GEOM_TRI: begin
        fbr[0] = bxe; fbr[1] = bye; fbr[2] = ONE_F - bxe - bye;
        fer[0] = exe; fer[1] = eye; fer[2] = ONE_F - exe - eye;
        used = 6'b000111;
      end
      resc_pkg::GEOM_SQUARE: begin
        fbr[0] = bxe; fbr[1] = bye; fbr[2] = ONE_F - bxe; fbr[3] = ONE_F - bye;
        fer[0] = exe; fer[1] = eye; fer[2] = ONE_F - exe; fer[3] = ONE_F - eye;
        used = 6'b001111;
      end
      resc_pkg::GEOM_TET: begin
        fbr[0] = bxe; fbr[1] = bye; fbr[2] = bze;
        fbr[3] = ONE_F - bxe - bye - bze;
        fer[0] = exe; fer[1] = eye; fer[2] = eze;
        fer[3] = ONE_F - exe - eye - eze;
        used = 6'b001111;
      end
      resc_pkg::GEOM_CUBE: begin
        fbr[0] = bxe; fbr[1] = bye; fbr[2] = bze;
        fbr[3] = ONE_F - bxe; fbr[4] = ONE_F - bye; fbr[5] = ONE_F - bze;
        fer[0] = exe; fer[1] = eye; fer[2] = eze;
        fer[3] = ONE_F - exe; fer[4] = ONE_F - eye; fer[5] = ONE_F - eze;
        used = 6'b111111;
      end
      default: begin
        pay_d[1].spec = 1'b1;
        pay_d[1].st   = resc_pkg::ST_BAD;
        pay_d[1].sx   = '0;
        pay_d[1].sy   = '0;
        pay_d[1].sz   = '0;
      end
    endcase

    // Begin coordinates are clamped at zero for the interpolation.
    pay_d[1].bx = (p.bx < 0) ? '0 : p.bx;
    pay_d[1].by = (p.by < 0) ? '0 : p.by;
    pay_d[1].bz = (p.bz < 0) ? '0 : p.bz;

    // A facet crosses when end lies on its negative side.
    for (int i = 0; i < NL; i++) begin
      fbc = (fbr[i] < 0) ? '0 : fbr[i];
      div0_d.act[i] = used[i] & fer[i][FW-1];
      div0_d.den[i] = DW'(fbc) - DW'(fer[i]);
      div0_d.rem[i] = {1'b0, fbc};
      div0_d.quo[i] = '0;
    end
  end

  // Restoring divider: one quotient bit per stage for every lane.
  always_comb begin
    logic [DW:0] r2;
    logic        bit_q;
    div_d[0] = div0_d;
    for (int j = 1; j <= F; j++) begin
      div_d[j] = div_q[j-1];
      for (int i = 0; i < NL; i++) begin
        r2    = {div_q[j-1].rem[i], 1'b0};
        bit_q = (r2 >= {1'b0, div_q[j-1].den[i]});
        div_d[j].rem[i] = bit_q ? DW'(r2 - {1'b0, div_q[j-1].den[i]}) : r2[DW-1:0];
        div_d[j].quo[i] = {div_q[j-1].quo[i][F-2:0], bit_q};
      end
    end
  end

  // Least crossing fraction over two stages, then the products.
  always_comb begin
    logic [TW-1:0] tl [NL];
    logic signed [CW:0] dl [3];
    for (int i = 0; i < NL; i++) begin
      tl[i] = div_q[F].act[i] ? {1'b0, div_q[F].quo[i]} : ONE_T;
    end
    for (int i = 0; i < 3; i++) begin
      ta_d[i] = (tl[2*i] < tl[2*i+1]) ? tl[2*i] : tl[2*i+1];
    end
    t_d = ta_q[0];
    if (ta_q[1] < t_d) begin
      t_d = ta_q[1];
    end
    if (ta_q[2] < t_d) begin
      t_d = ta_q[2];
    end
    dl[0] = (CW+1)'(pay_q[SB].ex) - (CW+1)'(pay_q[SB].bx);
    dl[1] = (CW+1)'(pay_q[SB].ey) - (CW+1)'(pay_q[SB].by);
    dl[2] = (CW+1)'(pay_q[SB].ez) - (CW+1)'(pay_q[SB].bz);
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = PW'($signed({1'b0, t_q}) * dl[i]);
    end
  end

  // Round, shift and add back the begin value; choose the result.
  always_comb begin
    logic signed [RW-1:0] r [3];
    logic signed [CW-1:0] b [3];
    logic dim3;
    pay_t p;
    p    = pay_q[SM];
    b[0] = p.bx;
    b[1] = p.by;
    b[2] = p.bz;
    for (int i = 0; i < 3; i++) begin
      r[i] = RW'(b[i]) + RW'(($signed(prod_q[i]) + HALF_P) >>> F);
    end
    dim3 = (p.geom == resc_pkg::GEOM_TET) || (p.geom == resc_pkg::GEOM_CUBE);
    if (p.spec) begin
      ox_d = p.sx;
      oy_d = p.sy;
      oz_d = p.sz;
      st_d = p.st;
    end else if (!out_c_q) begin
      ox_d = p.ex;
      oy_d = p.ey;
      oz_d = p.ez;
      st_d = resc_pkg::ST_INSIDE;
    end else begin
      ox_d = sat_f(r[0]);
      oy_d = sat_f(r[1]);
      oz_d = dim3 ? sat_f(r[2]) : p.ez;
      st_d = resc_pkg::ST_CLIPPED;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS - 1; k++) begin
      if (en[k]) begin
        pay_q[k] <= pay_d[k];
      end
    end
    for (int j = 0; j <= F; j++) begin
      if (en[j+1]) begin
        div_q[j] <= div_d[j];
      end
    end
    if (en[SA]) begin
      ta_q    <= ta_d;
      out_a_q <= |div_q[F].act;
    end
    if (en[SB]) begin
      t_q     <= t_d;
      out_b_q <= out_a_q;
    end
    if (en[SM]) begin
      prod_q  <= prod_d;
      out_c_q <= out_b_q;
    end
    if (en[NS-1]) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
      oz_q <= oz_d;
      st_q <= st_d;
    end
  end

  // The input only stalls when every stage holds an item.
  `RESC_ASSERT(a_full_when_stalled, clk_i, rst_ni, !s_axis_tready_o |-> &v_q)
  // The least crossing fraction never exceeds one.
  `RESC_ASSERT(a_t_bound, clk_i, rst_ni, v_q[SB] |-> (t_q <= ONE_T))
  // An unknown shape always comes out at the origin.
  `RESC_NEVER(a_bad_zero, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o == resc_pkg::ST_BAD) && (m_axis_tdata_o != '0))

endmodule

// ----- verif/reference_element_segment_clip_test.sv -----
// Self-checking stream testbench for the reference element segment clipper.
module reference_element_segment_clip_test;

  localparam int CW = 32;
  localparam int FB = 28;
  localparam int IW = ((6*CW+7)/8)*8;
  localparam int OW = ((3*CW+7)/8)*8;
  localparam longint ONE = longint'(1) << FB;
  localparam int LIMIT = 400000;
  localparam int MAX_ITEMS_RANDOM = 1150;

  typedef struct packed {
    logic [2:0] geom;
    logic signed [CW-1:0] bx, by, bz, ex, ey, ez;
  } clip_req_t;

  typedef struct packed {
    logic signed [CW-1:0] x, y, z;
    resc_pkg::status_e st;
  } clip_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IW-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OW-1:0] m_tdata;
  logic [1:0] m_tuser;

  clip_res_t expected_q[$];
  int mismatches = 0;
  int received = 0;
  int sent = 0;
  int cycles = 0;

  reference_element_segment_clip #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Saturate a wide value into the coordinate width.
  function automatic logic signed [CW-1:0] saturate(longint v);
    longint hi, lo;
    hi = (longint'(1) << (CW-1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Floor of a signed value divided by 2^FB.
  function automatic longint floor_frac(longint q);
    return q >>> FB;
  endfunction

  // Facet clipping: least crossing fraction, then interpolation from begin.
  function automatic bit facet_clip(int n, int dim, ref longint fb[6], ref longint fe[6],
                                    ref longint pt[3]);
    longint unsigned t, num, den, ti;
    bit outside;
    t = longint'(1) << FB;
    outside = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (fb[i] < 0) fb[i] = 0;
      if (fe[i] < 0) begin
        num = longint'(fb[i]) << FB;
        den = fb[i] - fe[i];
        ti = num / den;
        outside = 1'b1;
        if (ti < t) t = ti;
      end
    end
    if (!outside) return 1'b1;
    for (int i = 0; i < dim; i++)
      pt[i] = fb[i] + floor_frac(longint'(t) * (fe[i] - fb[i]) + (longint'(1) << (FB-1)));
    return 1'b0;
  endfunction

  // Predict the clipped point and status of one request.
  function automatic clip_res_t predict_clip(clip_req_t r);
    longint bx, by, bz, ex, ey, ez;
    longint pt[3];
    longint fb[6], fe[6];
    resc_pkg::status_e st;
    bit ok;
    clip_res_t res;
    bx = r.bx; by = r.by; bz = r.bz; ex = r.ex; ey = r.ey; ez = r.ez;
    pt[0] = ex; pt[1] = ey; pt[2] = ez;
    st = resc_pkg::ST_INSIDE;
    ok = 1'b1;
    foreach (fb[i]) begin
      fb[i] = 0; fe[i] = 0;
    end
    case (r.geom)
      resc_pkg::GEOM_POINT: if (ex != 0) begin
        pt[0] = 0; st = resc_pkg::ST_CLIPPED;
      end
      resc_pkg::GEOM_SEG: begin
        if (ex < 0) begin
          pt[0] = 0; st = resc_pkg::ST_CLIPPED;
        end else if (ex > ONE) begin
          pt[0] = ONE; st = resc_pkg::ST_CLIPPED;
        end
      end
      resc_pkg::GEOM_TRI: begin
        fb[0] = bx; fb[1] = by; fb[2] = ONE - bx - by;
        fe[0] = ex; fe[1] = ey; fe[2] = ONE - ex - ey;
        ok = facet_clip(3, 2, fb, fe, pt);
      end
      resc_pkg::GEOM_SQUARE: begin
        fb[0] = bx; fb[1] = by; fb[2] = ONE - bx; fb[3] = ONE - by;
        fe[0] = ex; fe[1] = ey; fe[2] = ONE - ex; fe[3] = ONE - ey;
        ok = facet_clip(4, 2, fb, fe, pt);
      end
      resc_pkg::GEOM_TET: begin
        fb[0] = bx; fb[1] = by; fb[2] = bz; fb[3] = ONE - bx - by - bz;
        fe[0] = ex; fe[1] = ey; fe[2] = ez; fe[3] = ONE - ex - ey - ez;
        ok = facet_clip(4, 3, fb, fe, pt);
      end
      resc_pkg::GEOM_CUBE: begin
        fb[0] = bx; fb[1] = by; fb[2] = bz;
        fb[3] = ONE - bx; fb[4] = ONE - by; fb[5] = ONE - bz;
        fe[0] = ex; fe[1] = ey; fe[2] = ez;
        fe[3] = ONE - ex; fe[4] = ONE - ey; fe[5] = ONE - ez;
        ok = facet_clip(6, 3, fb, fe, pt);
      end
      default: begin
        pt[0] = 0; pt[1] = 0; pt[2] = 0; st = resc_pkg::ST_BAD;
      end
    endcase
    if (!ok) st = resc_pkg::ST_CLIPPED;
    res.x = saturate(pt[0]);
    res.y = saturate(pt[1]);
    res.z = saturate(pt[2]);
    res.st = st;
    return res;
  endfunction

  // Send one request as a transfer after a random gap, recording its prediction.
  task automatic send_request(clip_req_t r);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.geom;
    s_tdata <= {r.ez, r.ey, r.ex, r.bz, r.by, r.bx};
    expected_q.push_back(predict_clip(r));
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sent++;
  endtask

  // Random coordinate, mostly near the unit range, sometimes anything.
  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return CW'(ONE);
      2: return '0;
      default: return CW'(longint'($urandom_range(0, 32'(3 * ONE))) - ONE);
    endcase
  endfunction

  function automatic clip_req_t rand_request(logic [2:0] geom);
    clip_req_t r;
    r.geom = geom;
    r.bx = rand_coord(); r.by = rand_coord(); r.bz = rand_coord();
    r.ex = rand_coord(); r.ey = rand_coord(); r.ez = rand_coord();
    // Most begin points sit inside the unit cell.
    if ($urandom_range(0, 3) != 0) begin
      r.bx = $urandom_range(0, 32'(ONE / 2));
      r.by = $urandom_range(0, 32'(ONE / 2));
      r.bz = $urandom_range(0, 32'(ONE / 4));
    end
    return r;
  endfunction

  // Extremes of every field and every shape, including unknown codes.
  task automatic test_directed();
    clip_req_t r;
    logic signed [CW-1:0] ext[4];
    ext[0] = {1'b1, {(CW-1){1'b0}}};
    ext[1] = {1'b0, {(CW-1){1'b1}}};
    ext[2] = '0;
    ext[3] = CW'(ONE);
    for (int g = 0; g < 8; g++) begin
      r.geom = g[2:0];
      r.bx = ext[g % 4]; r.by = ext[(g + 1) % 4]; r.bz = ext[(g + 2) % 4];
      r.ex = ext[(g + 3) % 4]; r.ey = ext[g % 4]; r.ez = ext[(g + 1) % 4];
      send_request(r);
    end
    // End inside, begin above one, and point at zero.
    r = '{geom: resc_pkg::GEOM_CUBE, bx: CW'(2 * ONE), by: CW'(ONE / 2), bz: CW'(ONE / 2),
          ex: CW'(ONE / 4), ey: CW'(ONE / 4), ez: CW'(ONE / 4)};
    send_request(r);
    r = '{geom: resc_pkg::GEOM_POINT, bx: 5, by: 6, bz: 7, ex: 0, ey: -1, ez: 1};
    send_request(r);
    r = '{geom: resc_pkg::GEOM_SEG, bx: 0, by: 0, bz: 0, ex: CW'(ONE + 1), ey: 3, ez: 4};
    send_request(r);
    r = '{geom: resc_pkg::GEOM_TRI, bx: CW'(ONE / 3), by: CW'(ONE / 3), bz: 0,
          ex: CW'(ONE), ey: CW'(ONE), ez: 9};
    send_request(r);
    r = '{geom: resc_pkg::GEOM_TET, bx: CW'(-ONE), by: 0, bz: 0, ex: -1, ey: -1, ez: -1};
    send_request(r);
    r = '{geom: resc_pkg::GEOM_SQUARE, bx: {1'b0, {(CW-1){1'b1}}},
          by: {1'b1, {(CW-1){1'b0}}},
          bz: -1, ex: -1, ey: {1'b1, {(CW-1){1'b0}}}, ez: -1};
    send_request(r);
  endtask

  // Random requests over all shape codes, mostly valid shapes.
  task automatic test_random();
    logic [2:0] g;
    for (int i = 0; i < MAX_ITEMS_RANDOM; i++) begin
      g = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_request(rand_request(g));
    end
  endtask

  // Check each result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    clip_res_t got, exp_r;
    if (rst_ni && m_tvalid && m_tready) begin
      got.x = m_tdata[CW-1:0];
      got.y = m_tdata[2*CW-1:CW];
      got.z = m_tdata[3*CW-1:2*CW];
      got.st = resc_pkg::status_e'(m_tuser);
      received++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  // Receiver stall: a random wait before each result.
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_n > 0) begin
        m_tready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4 * (FB + 5)) @(posedge clk_i);
    $display("Sent %0d requests over all shape codes, checked %0d results, %0d mismatches.",
             sent, received, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
